// ===== hdl/indexed_dary_min_heap_unit_macros.svh =====
// assertion macros shared by the heap unit rtl
// depends on nothing; included by files that carry assertions
`ifndef INDEXED_DARY_MIN_HEAP_UNIT_MACROS_SVH
`define INDEXED_DARY_MIN_HEAP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DHP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("dhp assertion failed");

// next-cycle implication, disabled during reset
`define DHP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("dhp next-cycle assertion failed");

`endif

// ===== hdl/dhp_pkg.sv =====
// types, codes and constants of the indexed d-ary min-heap unit
// depends on nothing
`timescale 1ns / 1ps

package dhp_pkg;

  localparam int DHP_VERT_CAP   = 1024;
  localparam int DHP_MAX_DEGREE = 8;

  localparam int MODE_W  = 2;
  localparam int VERT_W  = 10;
  localparam int DIST_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 4;

  // parent index = (i * recip) >> RECIP_SHIFT, exact for i < 2^16, degree <= 16
  localparam int RECIP_SHIFT = 21;
  localparam logic [20:0] DHP_RECIP [0:16] = '{
    21'd0,      21'd0,      21'd1048576, 21'd699051, 21'd524288,
    21'd419431, 21'd349526, 21'd299594,  21'd262144, 21'd233017,
    21'd209716, 21'd190651, 21'd174763,  21'd161320, 21'd149797,
    21'd139811, 21'd131072
  };

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEC  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PUSH_IGN  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DEC_IGN   = 2'd3;

  typedef struct packed {
    logic signed [DIST_W-1:0] key;
    logic [VERT_W-1:0]        vert;
  } dhp_entry_t;

endpackage

// ===== hdl/dhp_in_if.sv =====
// operation channel of the heap unit: valid/ready plus one operation beat
// depends on dhp_pkg
`timescale 1ns / 1ps

interface dhp_in_if import dhp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [VERT_W-1:0]        vertex;
  logic signed [DIST_W-1:0] distance;

  modport source (output valid, mode, vertex, distance, input ready);
  modport sink   (input valid, mode, vertex, distance, output ready);
endinterface

// ===== hdl/dhp_out_if.sv =====
// result channel of the heap unit: valid/ready plus one result beat
// depends on dhp_pkg
`timescale 1ns / 1ps

interface dhp_out_if import dhp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [VERT_W-1:0]        out_vertex;
  logic signed [DIST_W-1:0] out_distance;
  logic                     heap_empty;
  logic [COUNT_W-1:0]       heap_count;

  modport source (output valid, status, out_vertex, out_distance, heap_empty, heap_count,
                  input ready);
  modport sink   (input valid, status, out_vertex, out_distance, heap_empty, heap_count,
                  output ready);
endinterface

// ===== hdl/dhp_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps

module dhp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/indexed_dary_min_heap_unit.sv =====
// indexed d-ary min-heap with decrease-key, top level
// depends on dhp_pkg, dhp_in_if, dhp_out_if, dhp_ram and the macros header
`timescale 1ns / 1ps
`include "indexed_dary_min_heap_unit_macros.svh"

// usage
// in_chan carries one operation per beat: push, pop or decrease key of a
// (vertex, distance) pair. out_chan returns exactly one result beat per
// operation: status, popped vertex and distance, and the heap's emptiness
// and entry count after the operation. cfg_we/cfg_data set the degree; a
// write is taken only while the heap is empty, and 0 or 1 act as 2.
// the heap entries sit in one ram and the vertex-to-position map in another,
// each with one registered read port; a sequencer walks the tree.
// a push or decrease key climbs level by level (parent index, parent read,
// compare); a pop moves the last entry to the root and sinks it, scanning
// the children of each level in turn. one item is worked at a time.
// after reset the position map is swept clear, one entry per cycle;
// in_chan.ready stays low until the sweep ends.
// results go to an output register: the next operation is accepted while a
// result waits, but that operation cannot finish until out_chan takes it.

module indexed_dary_min_heap_unit import dhp_pkg::*; #(
  parameter int VERT_CAP   = DHP_VERT_CAP,
  parameter int MAX_DEGREE = DHP_MAX_DEGREE
) (
  input  logic             clk,
  input  logic             rst_n,
  dhp_in_if.sink           in_chan,
  dhp_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(VERT_CAP);          // heap position / vertex address
  localparam int CW = $clog2(VERT_CAP + 1);      // entry count
  localparam int DW = $clog2(MAX_DEGREE + 1);    // effective degree
  localparam int FW = AW + DW + 1;               // child index before bounding
  localparam int PW = AW + 1;                    // map word: present bit and position

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISP, ST_POP_LAST, ST_DK_CMP,
    ST_SU_DIV, ST_SU_RD, ST_SU_CMP,
    ST_SD_START, ST_SD_CHK, ST_SD_CMP, ST_DONE
  } state_t;

  state_t                   state_r;
  logic [MODE_W-1:0]        mode_r;
  logic [VERT_W-1:0]        vtx_r;
  logic signed [DIST_W-1:0] dist_r;
  logic [CW-1:0]            cnt_r;
  logic [DW-1:0]            ed_r;
  logic [AW-1:0]            at_r;
  logic [AW-1:0]            par_r;
  logic [AW-1:0]            clr_r;
  dhp_entry_t               cur_r;
  dhp_entry_t               best_r;
  logic [AW-1:0]            best_idx_r;
  logic [FW-1:0]            c_r;
  logic [FW-1:0]            stop_r;
  logic [STAT_W-1:0]        status_r;
  logic [VERT_W-1:0]        ov_r;
  logic signed [DIST_W-1:0] od_r;

  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [VERT_W-1:0]        out_vert_r;
  logic signed [DIST_W-1:0] out_dist_r;
  logic                     out_empty_r;
  logic [COUNT_W-1:0]       out_count_r;

  // ram ports
  logic          hp_we, pm_we;
  logic [AW-1:0] hp_wa, hp_ra, pm_wa, pm_ra;
  dhp_entry_t    hp_wd, hp_rd;
  logic [PW-1:0] pm_wd, pm_rd;

  logic              in_acc;
  logic              vbad;
  logic [AW-1:0]     up_x;
  logic [AW+20:0]    up_prod;
  logic [AW-1:0]     up_idx;
  logic              su_less;
  logic              sd_better;
  dhp_entry_t        sd_best;
  logic [AW-1:0]     sd_best_idx;
  logic [FW-1:0]     sd_nc;
  logic [DW-1:0]     cfg_deg;

  dhp_ram #(.WIDTH($bits(dhp_entry_t)), .DEPTH(VERT_CAP)) u_heap_ram (
    .clk   (clk),
    .we    (hp_we),
    .waddr (hp_wa),
    .wdata (hp_wd),
    .raddr (hp_ra),
    .rdata (hp_rd)
  );

  dhp_ram #(.WIDTH(PW), .DEPTH(VERT_CAP)) u_pmap_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_wa),
    .wdata (pm_wd),
    .raddr (pm_ra),
    .rdata (pm_rd)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && (state_r == ST_IDLE);

  // vertex beyond the map is never present
  assign vbad = (32'(vtx_r) >= 32'(VERT_CAP));

  // parent of at: (at - 1) / degree, by reciprocal multiply
  assign up_x    = at_r - AW'(1);
  assign up_prod = (AW+21)'(up_x) * (AW+21)'(DHP_RECIP[ed_r]);
  assign up_idx  = up_prod[AW+20:RECIP_SHIFT];

  assign su_less = (cur_r.key < hp_rd.key);

  // child scan: the first strictly smaller child wins
  assign sd_better   = (hp_rd.key < best_r.key);
  assign sd_best     = sd_better ? hp_rd : best_r;
  assign sd_best_idx = sd_better ? c_r[AW-1:0] : best_idx_r;
  assign sd_nc       = c_r + FW'(1);

  always_comb begin
    if (cfg_data < CFG_W'(2)) begin
      cfg_deg = DW'(2);
    end else if (32'(cfg_data) > 32'(MAX_DEGREE)) begin
      cfg_deg = DW'(MAX_DEGREE);
    end else begin
      cfg_deg = DW'(cfg_data);
    end
  end

  // ram addressing per state
  always_comb begin
    hp_we = 1'b0;
    hp_wa = at_r;
    hp_wd = cur_r;
    hp_ra = at_r;
    pm_we = 1'b0;
    pm_wa = AW'(cur_r.vert);
    pm_wd = {1'b1, at_r};
    pm_ra = AW'(in_chan.vertex);
    case (state_r)
      ST_CLEAR: begin
        pm_we = 1'b1;
        pm_wa = clr_r;
        pm_wd = '0;
      end
      ST_IDLE: begin
        hp_ra = '0;
      end
      ST_DISP: begin
        if (mode_r == MODE_POP && cnt_r != '0) begin
          // root leaves the map, last entry is fetched
          pm_we = 1'b1;
          pm_wa = AW'(hp_rd.vert);
          pm_wd = '0;
          hp_ra = AW'(cnt_r - CW'(1));
        end else if (mode_r == MODE_DEC) begin
          hp_ra = pm_rd[AW-1:0];
        end
      end
      ST_SU_DIV: begin
        if (at_r == '0) begin
          hp_we = 1'b1;
          pm_we = 1'b1;
        end
      end
      ST_SU_RD: begin
        hp_ra = par_r;
      end
      ST_SU_CMP: begin
        hp_we = 1'b1;
        pm_we = 1'b1;
        if (su_less) begin
          // parent moves down into the hole
          hp_wd = hp_rd;
          pm_wa = AW'(hp_rd.vert);
        end
      end
      ST_SD_CHK: begin
        hp_ra = c_r[AW-1:0];
        if (c_r >= FW'(cnt_r)) begin
          hp_we = 1'b1;
          pm_we = 1'b1;
        end
      end
      ST_SD_CMP: begin
        hp_ra = sd_nc[AW-1:0];
        if (sd_nc >= stop_r) begin
          hp_we = 1'b1;
          pm_we = 1'b1;
          if (sd_best_idx != at_r) begin
            // best child moves up into the hole
            hp_wd = sd_best;
            pm_wa = AW'(sd_best.vert);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      ed_r        <= DW'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cnt_r == '0) begin
        ed_r <= cfg_deg;
      end
      // the done state reloads the output register itself
      if (out_chan.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == VERT_CAP - 1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            mode_r   <= in_chan.mode;
            vtx_r    <= in_chan.vertex;
            dist_r   <= in_chan.distance;
            status_r <= STAT_DONE;
            ov_r     <= '0;
            od_r     <= '0;
            state_r  <= ST_DISP;
          end
        end
        ST_DISP: begin
          case (mode_r)
            MODE_PUSH: begin
              if (vbad || pm_rd[AW] || cnt_r >= CW'(VERT_CAP)) begin
                status_r <= STAT_PUSH_IGN;
                state_r  <= ST_DONE;
              end else begin
                cur_r   <= '{key: dist_r, vert: vtx_r};
                at_r    <= AW'(cnt_r);
                cnt_r   <= cnt_r + CW'(1);
                state_r <= ST_SU_DIV;
              end
            end
            MODE_POP: begin
              if (cnt_r == '0) begin
                status_r <= STAT_POP_EMPTY;
                state_r  <= ST_DONE;
              end else begin
                ov_r  <= hp_rd.vert;
                od_r  <= hp_rd.key;
                cnt_r <= cnt_r - CW'(1);
                if (cnt_r == CW'(1)) begin
                  state_r <= ST_DONE;
                end else begin
                  state_r <= ST_POP_LAST;
                end
              end
            end
            MODE_DEC: begin
              if (vbad || !pm_rd[AW]) begin
                status_r <= STAT_DEC_IGN;
                state_r  <= ST_DONE;
              end else begin
                at_r    <= pm_rd[AW-1:0];
                state_r <= ST_DK_CMP;
              end
            end
            default: begin
              state_r <= ST_DONE;
            end
          endcase
        end
        ST_POP_LAST: begin
          cur_r   <= hp_rd;
          at_r    <= '0;
          state_r <= ST_SD_START;
        end
        ST_DK_CMP: begin
          if (CW'(at_r) >= cnt_r || dist_r > hp_rd.key) begin
            status_r <= STAT_DEC_IGN;
            state_r  <= ST_DONE;
          end else begin
            cur_r   <= '{key: dist_r, vert: hp_rd.vert};
            state_r <= ST_SU_DIV;
          end
        end
        ST_SU_DIV: begin
          if (at_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            par_r   <= up_idx;
            state_r <= ST_SU_RD;
          end
        end
        ST_SU_RD: begin
          state_r <= ST_SU_CMP;
        end
        ST_SU_CMP: begin
          if (su_less) begin
            at_r    <= par_r;
            state_r <= ST_SU_DIV;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_SD_START: begin
          c_r     <= FW'(ed_r) * FW'(at_r) + FW'(1);
          state_r <= ST_SD_CHK;
        end
        ST_SD_CHK: begin
          if (c_r >= FW'(cnt_r)) begin
            state_r <= ST_DONE;
          end else begin
            best_r     <= cur_r;
            best_idx_r <= at_r;
            if (c_r + FW'(ed_r) > FW'(cnt_r)) begin
              stop_r <= FW'(cnt_r);
            end else begin
              stop_r <= c_r + FW'(ed_r);
            end
            state_r <= ST_SD_CMP;
          end
        end
        ST_SD_CMP: begin
          best_r     <= sd_best;
          best_idx_r <= sd_best_idx;
          if (sd_nc < stop_r) begin
            c_r <= sd_nc;
          end else if (sd_best_idx == at_r) begin
            state_r <= ST_DONE;
          end else begin
            at_r    <= sd_best_idx;
            state_r <= ST_SD_START;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_vert_r   <= ov_r;
            out_dist_r   <= od_r;
            out_empty_r  <= (cnt_r == '0);
            out_count_r  <= COUNT_W'(cnt_r);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.out_vertex   = out_vert_r;
  assign out_chan.out_distance = out_dist_r;
  assign out_chan.heap_empty   = out_empty_r;
  assign out_chan.heap_count   = out_count_r;

  `DHP_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(VERT_CAP))
  `DHP_ASSERT_IMP(a_deg_range, clk, rst_n, 1'b1, ed_r >= DW'(2) && ed_r <= DW'(MAX_DEGREE))
  `DHP_ASSERT_IMP(a_scan_in_heap, clk, rst_n, state_r == ST_SD_CMP, c_r < FW'(cnt_r))
  `DHP_ASSERT_NXT(a_accept_dispatch, clk, rst_n, in_acc, state_r == ST_DISP)
  `DHP_ASSERT_IMP(a_pop_empty_flag, clk, rst_n, out_valid_r && out_status_r == STAT_POP_EMPTY, out_empty_r)

endmodule

// ===== bench/indexed_dary_min_heap_unit_test.sv =====
// self-checking bench of the indexed d-ary min-heap unit: directed table, then random ops
// depends on dhp_pkg, dhp_in_if, dhp_out_if and indexed_dary_min_heap_unit
`timescale 1ns / 1ps

module indexed_dary_min_heap_unit_test;
  import dhp_pkg::*;

  localparam int NV = DHP_VERT_CAP;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_OPS = 1500;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [VERT_W-1:0]        vert;
    logic signed [DIST_W-1:0] key;
    logic                     empty;
    logic [COUNT_W-1:0]       count;
  } heap_result_t;

  // one row of the directed table; has_exp marks rows whose result is typed in
  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [VERT_W-1:0]        vert;
    logic signed [DIST_W-1:0] key;
    bit                       has_exp;
    heap_result_t             exp;
  } op_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  dhp_in_if  op_chan ();
  dhp_out_if res_chan ();

  indexed_dary_min_heap_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (op_chan.sink),
    .out_chan (res_chan.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // shadow heap kept by the bench
  logic signed [DIST_W-1:0] sh_dist [NV];
  logic [VERT_W-1:0]        sh_vert [NV];
  bit                       sh_present [NV];
  int unsigned              sh_pos [NV];
  int unsigned              sh_count;
  int unsigned              sh_degree;

  heap_result_t pending_results[$];
  int  error_count;
  int  idle_cycles;
  bit  no_idle;       // long stretch with both sides busy
  bit  stim_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic signed [DIST_W-1:0] td;
    logic [VERT_W-1:0] tv;
    td = sh_dist[a]; tv = sh_vert[a];
    sh_dist[a] = sh_dist[b]; sh_vert[a] = sh_vert[b];
    sh_dist[b] = td; sh_vert[b] = tv;
    sh_pos[sh_vert[a]] = a;
    sh_pos[sh_vert[b]] = b;
  endfunction

  function automatic void climb(int unsigned at);
    int unsigned up;
    while (at > 0) begin
      up = (at - 1) / sh_degree;
      if (sh_dist[at] < sh_dist[up]) begin
        swap_slots(at, up);
        at = up;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void descend(int unsigned at);
    int unsigned best, first, stop;
    forever begin
      best = at;
      first = sh_degree * at + 1;
      stop = first + sh_degree;
      if (stop > sh_count) stop = sh_count;
      for (int unsigned c = first; c < stop; c++)
        if (sh_dist[c] < sh_dist[best]) best = c;
      if (best == at) break;
      swap_slots(at, best);
      at = best;
    end
  endfunction

  function automatic void write_degree(logic [CFG_W-1:0] v);
    if (sh_count == 0) sh_degree = (v < 2) ? 2 : (v > DHP_MAX_DEGREE) ? DHP_MAX_DEGREE : v;
  endfunction

  // applies one operation to the shadow heap and returns the result it must give
  function automatic heap_result_t apply_heap_op(logic [MODE_W-1:0] mode,
                                                 logic [VERT_W-1:0] v,
                                                 logic signed [DIST_W-1:0] d);
    heap_result_t r;
    int unsigned at;
    r = '0;
    r.status = STAT_DONE;
    case (mode)
      MODE_PUSH: begin
        if (sh_present[v] || sh_count >= NV) begin
          r.status = STAT_PUSH_IGN;
        end else begin
          at = sh_count;
          sh_dist[at] = d; sh_vert[at] = v;
          sh_present[v] = 1'b1; sh_pos[v] = at;
          sh_count++;
          climb(at);
        end
      end
      MODE_POP: begin
        if (sh_count == 0) begin
          r.status = STAT_POP_EMPTY;
        end else begin
          r.vert = sh_vert[0];
          r.key = sh_dist[0];
          sh_present[sh_vert[0]] = 1'b0;
          sh_count--;
          if (sh_count > 0) begin
            sh_dist[0] = sh_dist[sh_count];
            sh_vert[0] = sh_vert[sh_count];
            sh_pos[sh_vert[0]] = 0;
            descend(0);
          end
        end
      end
      MODE_DEC: begin
        if (!sh_present[v] || d > sh_dist[sh_pos[v]]) begin
          r.status = STAT_DEC_IGN;
        end else begin
          sh_dist[sh_pos[v]] = d;
          climb(sh_pos[v]);
        end
      end
      default: ;  // mode three does nothing
    endcase
    r.empty = (sh_count == 0);
    r.count = sh_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(99) < 27);
  endfunction

  // sends one operation beat and queues what it must return
  // valid stays high into the next beat; drain_results drops it
  task automatic send_op(logic [MODE_W-1:0] mode, logic [VERT_W-1:0] v,
                         logic signed [DIST_W-1:0] d, bit has_exp, heap_result_t typed);
    heap_result_t pred;
    if (idle_roll()) begin
      op_chan.valid <= 1'b0;
      @(posedge clk);
      while (idle_roll()) @(posedge clk);
    end
    op_chan.valid    <= 1'b1;
    op_chan.mode     <= mode;
    op_chan.vertex   <= v;
    op_chan.distance <= d;
    @(posedge clk);
    while (!op_chan.ready) @(posedge clk);
    pred = apply_heap_op(mode, v, d);
    if (has_exp && pred != typed) begin
      $error("table row disagrees with shadow heap: typed %h shadow %h", typed, pred);
      error_count++;
    end
    pending_results.push_back(has_exp ? typed : pred);
  endtask

  task automatic drain_results();
    op_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_degree(logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    write_degree(v);
  endtask

  task automatic empty_heap();
    heap_result_t none;
    none = '0;
    while (sh_count != 0) send_op(MODE_POP, '0, '0, 1'b0, none);
    drain_results();
  endtask

  // result side: random stalls, field by field compare against oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_chan.valid && res_chan.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: status %0d", res_chan.status);
          error_count++;
        end else begin
          heap_result_t e;
          e = pending_results.pop_front();
          if (res_chan.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, res_chan.status);
            error_count++;
          end
          if (res_chan.out_vertex !== e.vert) begin
            $error("out_vertex: expected %0d actual %0d", e.vert, res_chan.out_vertex);
            error_count++;
          end
          if (res_chan.out_distance !== e.key) begin
            $error("out_distance: expected %0d actual %0d", e.key, res_chan.out_distance);
            error_count++;
          end
          if (res_chan.heap_empty !== e.empty) begin
            $error("heap_empty: expected %0d actual %0d", e.empty, res_chan.heap_empty);
            error_count++;
          end
          if (res_chan.heap_count !== e.count) begin
            $error("heap_count: expected %0d actual %0d", e.count, res_chan.heap_count);
            error_count++;
          end
        end
      end
      res_chan.ready <= !idle_roll();
    end else begin
      res_chan.ready <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted beat; the reset sweep is covered by the limit
  always @(posedge clk) begin
    if ((op_chan.valid && op_chan.ready) || (res_chan.valid && res_chan.ready) ||
        (stim_done && pending_results.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic heap_result_t res(logic [STAT_W-1:0] s, logic [VERT_W-1:0] v,
                                       logic signed [DIST_W-1:0] d, int unsigned c);
    heap_result_t r;
    r.status = s; r.vert = v; r.key = d; r.empty = (c == 0); r.count = COUNT_W'(c);
    return r;
  endfunction

  initial begin
    op_row_t rows[$];
    heap_result_t none;
    logic [MODE_W-1:0] m;
    logic [VERT_W-1:0] v;
    logic signed [DIST_W-1:0] d;
    int unsigned pick;
    logic [CFG_W-1:0] deg_seq [8];
    none = '0;
    deg_seq = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd5, 4'd2, 4'd7};
    error_count = 0;
    no_idle = 1'b0;
    stim_done = 1'b0;
    sh_count = 0;
    sh_degree = 2;
    for (int i = 0; i < NV; i++) begin
      sh_present[i] = 1'b0; sh_pos[i] = 0;
    end
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    op_chan.valid = 1'b0;
    op_chan.mode = MODE_PUSH;
    op_chan.vertex = '0;
    op_chan.distance = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: empty pop, extremes, ignored cases, mode three, ties
    rows = '{
      '{MODE_POP,  10'd0,    32'sd0,          1'b1, res(STAT_POP_EMPTY, '0, '0, 0)},
      '{MODE_DEC,  10'd5,    32'sd0,          1'b1, res(STAT_DEC_IGN, '0, '0, 0)},
      '{MODE_NOP,  10'd1023, -32'sd1,         1'b1, res(STAT_DONE, '0, '0, 0)},
      '{MODE_PUSH, 10'd1023, 32'h7fffffff,    1'b1, res(STAT_DONE, '0, '0, 1)},
      '{MODE_PUSH, 10'd1023, 32'sd5,          1'b1, res(STAT_PUSH_IGN, '0, '0, 1)},
      '{MODE_PUSH, 10'd0,    32'h80000000,    1'b1, res(STAT_DONE, '0, '0, 2)},
      '{MODE_PUSH, 10'd512,  32'sd7,          1'b0, none},
      '{MODE_PUSH, 10'd341,  32'sd7,          1'b0, none},
      '{MODE_PUSH, 10'd682,  -32'sd2,         1'b0, none},
      '{MODE_DEC,  10'd512,  32'sd9,          1'b0, none},
      '{MODE_DEC,  10'd512,  32'sd7,          1'b0, none},
      '{MODE_DEC,  10'd1023, 32'h80000000,    1'b0, none},
      '{MODE_NOP,  10'd3,    32'sd3,          1'b0, none},
      '{MODE_POP,  10'd0,    32'sd0,          1'b0, none},
      '{MODE_POP,  10'd0,    32'sd0,          1'b0, none},
      '{MODE_POP,  10'd0,    32'sd0,          1'b0, none},
      '{MODE_POP,  10'd0,    32'sd0,          1'b0, none},
      '{MODE_POP,  10'd0,    32'sd0,          1'b0, none},
      '{MODE_POP,  10'd0,    32'sd0,          1'b0, none},
      '{MODE_POP,  10'd0,    32'sd0,          1'b1, res(STAT_POP_EMPTY, '0, '0, 0)}
    };
    foreach (rows[i]) send_op(rows[i].mode, rows[i].vert, rows[i].key,
                              rows[i].has_exp, rows[i].exp);
    drain_results();

    // random phases, one per degree setting; includes out-of-range values
    for (int ph = 0; ph < 8; ph++) begin
      set_degree(deg_seq[ph]);
      if (ph == 3) begin
        // write while non-empty must be dropped
        send_op(MODE_PUSH, 10'd77, 32'sd1, 1'b0, none);
        drain_results();
        set_degree(4'd6);
        empty_heap();
      end
      no_idle = (ph == 4);
      for (int k = 0; k < RANDOM_OPS / 8; k++) begin
        pick = $urandom_range(99);
        // small vertex pool on some phases so repeats and present-checks are common
        v = (ph % 2) ? VERT_W'($urandom_range(NV - 1)) : VERT_W'($urandom_range(31));
        case ($urandom_range(3))
          0: d = $urandom;
          1: d = $signed($urandom_range(40)) - 20;
          2: d = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
          default: d = $signed($urandom_range(2000)) - 1000;
        endcase
        if (pick < 45) m = MODE_PUSH;
        else if (pick < 75) m = MODE_POP;
        else if (pick < 97) m = MODE_DEC;
        else m = MODE_NOP;
        // decrease keys mostly aimed at present vertices
        if (m == MODE_DEC && sh_count != 0 && $urandom_range(3) != 0) begin
          v = sh_vert[$urandom_range(sh_count - 1)];
          if ($urandom_range(4) != 0) d = sh_dist[sh_pos[v]] - $urandom_range(50);
        end
        send_op(m, v, d, 1'b0, none);
      end
      empty_heap();
    end
    no_idle = 1'b0;

    stim_done = 1'b1;
    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dhp_pkg.sv
hdl/dhp_in_if.sv
hdl/dhp_out_if.sv
hdl/dhp_ram.sv
hdl/indexed_dary_min_heap_unit.sv
bench/indexed_dary_min_heap_unit_test.sv
